@@ design/ibor_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibor_pkg: shared types and constants of the open-row bank model
// Field widths, register indexes, sequencer states and the row-table control.
// ----------------------------------------------------------------------------
package ibor_pkg;

    localparam int TOKEN_W    = 20;
    localparam int HEAD_W     = 10;
    localparam int HDIM_W     = 11;
    localparam int ROWB_W     = 17;
    localparam int COST_W     = 8;
    localparam int NBITS_W    = 3;
    localparam int IDX_W      = 31;   // token * 2047 + 1023 fits in 31 bits
    localparam int DIVIDEND_W = 42;   // (idx >> n) * head_dimension
    localparam int DIVISOR_W  = 16;   // (row_bytes >> 2) + 1 <= 32768
    localparam int ROW_W      = 40;
    localparam int CNT_W      = 64;
    localparam int BANK_OUT_W = 4;
    localparam int ADDR_W     = 5;
    localparam int APB_DW     = 32;

    typedef enum logic [2:0] {
        REG_BANK_LOG2 = 3'd0,
        REG_HEAD_DIM  = 3'd1,
        REG_ROW_BYTES = 3'd2,
        REG_PRECHARGE = 3'd3,
        REG_ACTIVATE  = 3'd4,
        REG_BURST     = 3'd5
    } t_reg_idx;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL1 = 5'b00010,
        ST_MUL2 = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_CMP  = 5'b10000
    } t_state;

    typedef struct packed {
        logic lookup;   // latch bank, read its open row
        logic update;   // resolve access, open the row on a miss
    } t_tbl_ctl;

endpackage

@@ design/ibor_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibor_div: bit-serial restoring divider
// One quotient bit per cycle; the dividend shifts out as the quotient shifts in.
// ----------------------------------------------------------------------------
module ibor_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ibor_pkg::DIVIDEND_W-1:0]  i_dividend,
    input  logic [ibor_pkg::DIVISOR_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [ibor_pkg::ROW_W-1:0]       o_quotient
);
    import ibor_pkg::*;

    localparam int CNT_BITS = $clog2(DIVIDEND_W);

    logic [DIVISOR_W-1:0]  r_rem,  n_rem;
    logic [DIVIDEND_W-1:0] r_quo,  n_quo;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    w_rem_sh;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[DIVIDEND_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_dvs};
        w_ge     = (w_rem_sh >= {1'b0, r_dvs});
        n_rem    = w_ge ? w_diff[DIVISOR_W-1:0] : w_rem_sh[DIVISOR_W-1:0];
        n_quo    = {r_quo[DIVIDEND_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_BITS'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[ROW_W-1:0];

endmodule

@@ design/ibor_row_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibor_row_table: per-bank open-row store
// Registered read of the bank's open row, hit compare, row open on a miss.
// ----------------------------------------------------------------------------
module ibor_row_table #(
    parameter int MAX_BANKS = 16,
    parameter int BANK_W    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ibor_pkg::t_tbl_ctl          i_ctl,
    input  logic [BANK_W-1:0]           i_bank,
    input  logic [ibor_pkg::ROW_W-1:0]  i_row,
    output logic                        o_hit
);
    import ibor_pkg::*;

    logic [ROW_W-1:0]     mem [MAX_BANKS];
    logic [MAX_BANKS-1:0] r_valid;
    logic [ROW_W-1:0]     r_rd_row;
    logic                 r_rd_vld;
    logic [BANK_W-1:0]    r_bank;

    assign o_hit = r_rd_vld && (r_rd_row == i_row);

    always_ff @(posedge i_clk) begin
        if (i_ctl.lookup) begin
            r_rd_row <= mem[r_bank_sel(i_bank)];
            r_bank   <= i_bank;
        end
        if (i_ctl.update && !o_hit) begin
            mem[r_bank_sel(r_bank)] <= i_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.lookup) begin
                r_rd_vld <= r_valid[r_bank_sel(i_bank)];
            end
            if (i_ctl.update && !o_hit) begin
                r_valid[r_bank_sel(r_bank)] <= 1'b1;
                r_rd_vld                    <= 1'b1;
            end
        end
    end

    // bank numbers never reach MAX_BANKS; the select only sizes the index
    function automatic logic [BANK_W-1:0] r_bank_sel(input logic [BANK_W-1:0] b);
        r_bank_sel = b;
    endfunction

endmodule

@@ design/interleaved_bank_open_row_model.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interleaved_bank_open_row_model: open-row bank model for key/value accesses
// Maps each access to a bank and row, tracks open rows, counts hits, misses
// and modeled cycle cost.
// ----------------------------------------------------------------------------
// Each input beat carries a token and a head index. The block forms
// idx = token * max(head_dimension,1) + head, takes the low bank_count_log2
// bits (capped at log2 of MAX_BANKS) as the bank, and computes the row as
// (idx >> n) * head_dimension / (row_bytes/4 + 1), kept to 40 bits. A match
// with the bank's open row is a hit (burst cost); otherwise a miss (precharge +
// activate + burst) that opens the row. One output beat per input beat carries
// bank, row, the hit flag and the three wrapping 64-bit totals after the
// access. From acceptance an item goes through the sequencer states in order:
// form the index, form the product and start the divider, the bit-serial
// divider (one quotient bit per cycle over the 42-bit product, then its done
// strobe) and the resolve step. Resolve waits while the output register holds
// an unread result. The next beat is accepted as soon as the sequencer is back
// in idle, even if the previous result still sits in the output register; a
// new beat is never taken before the previous one has been resolved. Open rows
// reset to none at once through per-bank valid flops; there is no clearing
// pass. Configuration writes go through the APB port and must be made while
// no access is in flight; reads return the register values.
// ----------------------------------------------------------------------------
module interleaved_bank_open_row_model #(
    parameter int MAX_BANKS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input beats
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,   // token_index[19:0], head_index[29:20]
    // result beats
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [239:0]                    m_axis_tdata,   // bank[3:0], row[43:4],
                                                            // hit_total[107:44],
                                                            // miss_total[171:108],
                                                            // cycle_total[235:172]
    output logic [0:0]                      m_axis_tuser,   // row_hit[0]
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ibor_pkg::ADDR_W-1:0]     paddr,
    input  logic [ibor_pkg::APB_DW-1:0]     pwdata,
    output logic [ibor_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import ibor_pkg::*;

    localparam int BANK_W = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
    localparam logic [NBITS_W-1:0] BANK_LIM = NBITS_W'($clog2(MAX_BANKS + 1) - 1);

    // ---------------- configuration registers ----------------
    logic [NBITS_W-1:0] r_cfg_nbits;
    logic [HDIM_W-1:0]  r_cfg_hd;
    logic [ROWB_W-1:0]  r_cfg_rowb;
    logic [COST_W-1:0]  r_cfg_pre;
    logic [COST_W-1:0]  r_cfg_act;
    logic [COST_W-1:0]  r_cfg_burst;

    logic w_cfg_wr;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_nbits <= NBITS_W'(0);
            r_cfg_hd    <= HDIM_W'(1);
            r_cfg_rowb  <= ROWB_W'(64);
            r_cfg_pre   <= COST_W'(2);
            r_cfg_act   <= COST_W'(2);
            r_cfg_burst <= COST_W'(1);
        end else if (w_cfg_wr) begin
            case (paddr[ADDR_W-1:2])
                REG_BANK_LOG2: r_cfg_nbits <= pwdata[NBITS_W-1:0];
                REG_HEAD_DIM:  r_cfg_hd    <= pwdata[HDIM_W-1:0];
                REG_ROW_BYTES: r_cfg_rowb  <= pwdata[ROWB_W-1:0];
                REG_PRECHARGE: r_cfg_pre   <= pwdata[COST_W-1:0];
                REG_ACTIVATE:  r_cfg_act   <= pwdata[COST_W-1:0];
                REG_BURST:     r_cfg_burst <= pwdata[COST_W-1:0];
                default: ;  // unmapped registers ignore writes
            endcase
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_BANK_LOG2: prdata = APB_DW'(r_cfg_nbits);
            REG_HEAD_DIM:  prdata = APB_DW'(r_cfg_hd);
            REG_ROW_BYTES: prdata = APB_DW'(r_cfg_rowb);
            REG_PRECHARGE: prdata = APB_DW'(r_cfg_pre);
            REG_ACTIVATE:  prdata = APB_DW'(r_cfg_act);
            REG_BURST:     prdata = APB_DW'(r_cfg_burst);
            default:       prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    t_state r_state, n_state;

    logic [TOKEN_W-1:0] r_token;
    logic [HEAD_W-1:0]  r_head;
    logic [IDX_W-1:0]   r_idx;
    logic [BANK_W-1:0]  r_bank;

    logic               w_in_fire;
    logic               w_out_free;
    logic               w_load;
    logic               w_hit;
    logic               w_div_done;
    logic [ROW_W-1:0]   w_row;
    t_tbl_ctl           w_tbl_ctl;

    // effective bank bits, capped by the bank count
    logic [NBITS_W-1:0]    w_nbits;
    logic [HDIM_W-1:0]     w_mult;
    logic [IDX_W-1:0]      w_idx_sh;
    logic [BANK_W-1:0]     w_bank_mask;
    logic [BANK_W-1:0]     w_bank;
    logic [DIVIDEND_W-1:0] w_prod;
    logic [DIVISOR_W-1:0]  w_divisor;

    always_comb begin
        w_nbits     = (r_cfg_nbits > BANK_LIM) ? BANK_LIM : r_cfg_nbits;
        w_mult      = (r_cfg_hd == '0) ? HDIM_W'(1) : r_cfg_hd;
        w_idx_sh    = r_idx >> w_nbits;
        w_bank_mask = BANK_W'((32'd1 << w_nbits) - 32'd1);
        w_bank      = r_idx[BANK_W-1:0] & w_bank_mask;
        w_prod      = {{(DIVIDEND_W-IDX_W){1'b0}}, w_idx_sh}
                    * {{(DIVIDEND_W-HDIM_W){1'b0}}, r_cfg_hd};
        w_divisor   = DIVISOR_W'(r_cfg_rowb >> 2) + DIVISOR_W'(1);
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !m_axis_tvalid || m_axis_tready;
    assign w_load        = (r_state == ST_CMP) && w_out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_fire)  n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_DIV;
            ST_DIV:  if (w_div_done) n_state = ST_CMP;
            ST_CMP:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_token <= s_axis_tdata[TOKEN_W-1:0];
            r_head  <= s_axis_tdata[TOKEN_W+HEAD_W-1:TOKEN_W];
        end
        if (r_state == ST_MUL1) begin
            r_idx <= ({{(IDX_W-TOKEN_W){1'b0}}, r_token} * {{(IDX_W-HDIM_W){1'b0}}, w_mult})
                   + {{(IDX_W-HEAD_W){1'b0}}, r_head};
        end
        if (r_state == ST_MUL2) begin
            r_bank <= w_bank;
        end
    end

    // ---------------- row divider ----------------
    ibor_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_MUL2),
        .i_dividend (w_prod),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_row)
    );

    // ---------------- open-row table ----------------
    assign w_tbl_ctl.lookup = (r_state == ST_MUL2);
    assign w_tbl_ctl.update = w_load;

    ibor_row_table #(
        .MAX_BANKS (MAX_BANKS),
        .BANK_W    (BANK_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_tbl_ctl),
        .i_bank  (w_bank),
        .i_row   (w_row),
        .o_hit   (w_hit)
    );

    // ---------------- counters and output register ----------------
    logic [CNT_W-1:0]  r_hit_cnt;
    logic [CNT_W-1:0]  r_miss_cnt;
    logic [CNT_W-1:0]  r_cyc_cnt;
    logic [COST_W+1:0] w_cost;

    assign w_cost = w_hit ? (COST_W+2)'(r_cfg_burst)
                          : (COST_W+2)'(r_cfg_pre) + (COST_W+2)'(r_cfg_act)
                          + (COST_W+2)'(r_cfg_burst);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            r_cyc_cnt  <= '0;
        end else if (w_load) begin
            if (w_hit) begin
                r_hit_cnt <= r_hit_cnt + CNT_W'(1);
            end else begin
                r_miss_cnt <= r_miss_cnt + CNT_W'(1);
            end
            r_cyc_cnt <= r_cyc_cnt + CNT_W'(w_cost);
        end
    end

    logic                  r_out_valid;
    logic [BANK_OUT_W-1:0] r_out_bank;
    logic [ROW_W-1:0]      r_out_row;
    logic                  r_out_hit;
    logic [CNT_W-1:0]      r_out_hits;
    logic [CNT_W-1:0]      r_out_misses;
    logic [CNT_W-1:0]      r_out_cycles;
    logic [BANK_W+BANK_OUT_W-1:0] w_bank_ext;

    assign w_bank_ext = {{BANK_OUT_W{1'b0}}, r_bank};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // totals reflect this access, so they take the updated counter values
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_bank   <= w_bank_ext[BANK_OUT_W-1:0];
            r_out_row    <= w_row;
            r_out_hit    <= w_hit;
            r_out_hits   <= w_hit ? r_hit_cnt + CNT_W'(1) : r_hit_cnt;
            r_out_misses <= w_hit ? r_miss_cnt : r_miss_cnt + CNT_W'(1);
            r_out_cycles <= r_cyc_cnt + CNT_W'(w_cost);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_cycles, r_out_misses, r_out_hits,
                            r_out_row, r_out_bank};
    assign m_axis_tuser  = r_out_hit;

`ifndef NO_ASSERTIONS
    // a resolved access always lands in the output register
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> m_axis_tvalid)
        else $error("resolved access did not reach the output register");

    // each resolved access bumps exactly one of the hit and miss counters
    a_one_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> ((r_hit_cnt == $past(r_hit_cnt) + CNT_W'(1))
                  != (r_miss_cnt == $past(r_miss_cnt) + CNT_W'(1))))
        else $error("hit/miss counters out of step");

    // divider completion is only expected while the sequencer waits for it
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide phase");

    // a stalled result is never overwritten by the next access
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !w_load)
        else $error("output register overwritten while stalled");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the open-row bank model
// Access beats come from a queue and go through a stalling stream driver.
// A shadow bank model predicts bank, row, the hit flag and the running
// totals. A stalling monitor compares each result beat against the oldest
// prediction. Register settings are changed over APB between drained phases.
// ----------------------------------------------------------------------------
module tb_top;
    import ibor_pkg::*;

    localparam int BANKS_MAX     = 16;
    localparam int BANK_SEL_MAX  = $clog2(BANKS_MAX);   // bank select bits saturate here
    localparam int REG_SPARE     = 6;                   // first register index past the file
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int IDLE_PCT      = 37;
    localparam int HOLD_AT       = 300;                 // results seen before the long stall
    localparam int HOLD_LEN      = 400;                 // length of the long stall, in cycles
    localparam int CALM_LO       = 800;                 // window with no idling on either side
    localparam int CALM_HI       = 1100;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 250;

    typedef struct packed {
        logic [TOKEN_W-1:0] token;
        logic [HEAD_W-1:0]  head;
    } t_access;

    typedef struct packed {
        logic [BANK_OUT_W-1:0] bank;
        logic [ROW_W-1:0]      row;
        logic                  hit;
        logic [CNT_W-1:0]      hits;
        logic [CNT_W-1:0]      misses;
        logic [CNT_W-1:0]      cycles;
    } t_outcome;

    // ------------------------------------------------------------------------
    // DUT connections; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata  = '0;   // token_index[19:0], head_index[29:20]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [239:0]         m_axis_tdata;         // bank[3:0], row[43:4], hit_total[107:44],
                                                // miss_total[171:108], cycle_total[235:172]
    logic [0:0]           m_axis_tuser;         // row_hit[0]
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [ADDR_W-1:0]    paddr         = '0;
    logic [APB_DW-1:0]    pwdata        = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    interleaved_bank_open_row_model #(
        .MAX_BANKS(BANKS_MAX)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow copy of the registers (reset values) and of the bank state
    // ------------------------------------------------------------------------
    logic [NBITS_W-1:0] cfg_nbits = '0;
    logic [HDIM_W-1:0]  cfg_hdim  = HDIM_W'(1);
    logic [ROWB_W-1:0]  cfg_rowb  = ROWB_W'(64);
    logic [COST_W-1:0]  cfg_pre   = COST_W'(2);
    logic [COST_W-1:0]  cfg_act   = COST_W'(2);
    logic [COST_W-1:0]  cfg_burst = COST_W'(1);

    logic [ROW_W-1:0]   shadow_row [BANKS_MAX] = '{default: '0};
    logic               open_vld [BANKS_MAX] = '{default: 1'b0};
    logic [CNT_W-1:0]   hit_cnt  = '0;
    logic [CNT_W-1:0]   miss_cnt = '0;
    logic [CNT_W-1:0]   cyc_cnt  = '0;

    t_access  access_queue [$];      // beats waiting for the driver
    t_outcome outcome_queue [$];     // predictions waiting for result beats
    t_access  beat_on_bus;           // beat currently offered on the input
    t_outcome want;

    int n_queued   = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int errors     = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int n_cycles   = 0;

    // Resolve one access against the open rows and advance the totals.
    // Zero head dimension: index multiplier is 1 but row multiplier is 0.
    // Bank select bits above log2(BANKS_MAX) are clipped; row keeps 40 bits.
    function automatic t_outcome resolve_access(input t_access a);
        logic [63:0] mult;
        logic [63:0] idx;
        logic [63:0] bank_no;
        logic [63:0] divisor;
        logic [63:0] row_full;
        int          sel_bits;
        int          slot;
        t_outcome    res;
        mult     = (cfg_hdim == '0) ? 64'd1 : 64'(cfg_hdim);
        sel_bits = (int'(cfg_nbits) > BANK_SEL_MAX) ? BANK_SEL_MAX : int'(cfg_nbits);
        idx      = 64'(a.token) * mult + 64'(a.head);
        bank_no  = idx & ((64'd1 << sel_bits) - 64'd1);
        divisor  = 64'(cfg_rowb >> 2) + 64'd1;
        row_full = ((idx >> sel_bits) * 64'(cfg_hdim)) / divisor;
        slot     = int'(bank_no);
        res.bank = bank_no[BANK_OUT_W-1:0];
        res.row  = row_full[ROW_W-1:0];
        res.hit  = open_vld[slot] && (shadow_row[slot] == res.row);
        if (res.hit) begin
            hit_cnt = hit_cnt + 64'd1;
            cyc_cnt = cyc_cnt + 64'(cfg_burst);
        end else begin
            miss_cnt = miss_cnt + 64'd1;
            cyc_cnt  = cyc_cnt + 64'(cfg_pre) + 64'(cfg_act) + 64'(cfg_burst);
            shadow_row[slot] = res.row;
            open_vld[slot]   = 1'b1;
        end
        res.hits   = hit_cnt;
        res.misses = miss_cnt;
        res.cycles = cyc_cnt;
        return res;
    endfunction

    task automatic check_field(input string fname, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, fname, exp_v, act_v);
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver: offers queued beats, idles at random outside the calm
    // window, holds a beat steady until the block takes it. Predictions are
    // made at the accepting edge, in acceptance order.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                outcome_queue.push_back(resolve_access(beat_on_bus));
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (access_queue.size() != 0 &&
                    ((n_accepted >= CALM_LO && n_accepted < CALM_HI) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    beat_on_bus = access_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, beat_on_bus.head, beat_on_bus.token};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: checks each beat field by field, backpressures at
    // random, and once holds tready low long enough for the block to stall
    // its input while the driver keeps offering.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (outcome_queue.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected, actual %0h",
                             $time, m_axis_tdata);
                end else begin
                    want = outcome_queue.pop_front();
                    check_field("bank",        64'(want.bank), 64'(m_axis_tdata[3:0]));
                    check_field("row",         64'(want.row),  64'(m_axis_tdata[43:4]));
                    check_field("row_hit",     64'(want.hit),  64'(m_axis_tuser[0]));
                    check_field("hit_total",   want.hits,      m_axis_tdata[107:44]);
                    check_field("miss_total",  want.misses,    m_axis_tdata[171:108]);
                    check_field("cycle_total", want.cycles,    m_axis_tdata[235:172]);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && n_results >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (n_results >= CALM_LO && n_results < CALM_HI) ||
                                 ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_access(input logic [TOKEN_W-1:0] token,
                                input logic [HEAD_W-1:0] head);
        t_access a;
        a.token = token;
        a.head  = head;
        access_queue.push_back(a);
        n_queued++;
    endtask

    // APB write: setup cycle, access cycle; shadow follows after the write edge.
    // Out-of-range indexes are written on the bus but change nothing.
    task automatic write_reg(input int idx, input logic [APB_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            int'(REG_BANK_LOG2): cfg_nbits = value[NBITS_W-1:0];
            int'(REG_HEAD_DIM):  cfg_hdim  = value[HDIM_W-1:0];
            int'(REG_ROW_BYTES): cfg_rowb  = value[ROWB_W-1:0];
            int'(REG_PRECHARGE): cfg_pre   = value[COST_W-1:0];
            int'(REG_ACTIVATE):  cfg_act   = value[COST_W-1:0];
            int'(REG_BURST):     cfg_burst = value[COST_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int nbits, input int hdim, input int rowb,
                              input int pre, input int act, input int burst);
        write_reg(int'(REG_BANK_LOG2), APB_DW'(nbits));
        write_reg(int'(REG_HEAD_DIM),  APB_DW'(hdim));
        write_reg(int'(REG_ROW_BYTES), APB_DW'(rowb));
        write_reg(int'(REG_PRECHARGE), APB_DW'(pre));
        write_reg(int'(REG_ACTIVATE),  APB_DW'(act));
        write_reg(int'(REG_BURST),     APB_DW'(burst));
    endtask

    // Sender pause: nothing new until every queued access has its result back
    task automatic wait_drained();
        while (n_results < n_queued)
            @(posedge i_clk);
    endtask

    function automatic int pick_cost();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 0;
        if (r == 1)
            return 255;
        return $urandom_range(0, 255);
    endfunction

    // Mostly streaming patterns (head walks, token walks, ping-pong between
    // two entries) so open rows get reused; the rest is full-range noise.
    task automatic fill_random(input int count);
        int                 made;
        int                 kind;
        int                 len;
        logic [TOKEN_W-1:0] tok;
        logic [HEAD_W-1:0]  hd;
        logic [TOKEN_W-1:0] alt_tok;
        logic [HEAD_W-1:0]  alt_hd;
        made = 0;
        while (made < count) begin
            kind    = $urandom_range(0, 9);
            len     = $urandom_range(2, 12);
            tok     = TOKEN_W'($urandom());
            hd      = HEAD_W'($urandom());
            alt_tok = TOKEN_W'($urandom());
            alt_hd  = HEAD_W'($urandom());
            for (int k = 0; k < len; k++) begin
                case (kind)
                    0, 1, 2: queue_access(tok, hd + HEAD_W'(k));
                    3, 4:    queue_access(tok + TOKEN_W'(k), hd);
                    5, 6: begin
                        if (k % 2 == 1)
                            queue_access(alt_tok, alt_hd);
                        else
                            queue_access(tok, hd);
                    end
                    default: queue_access(TOKEN_W'($urandom()), HEAD_W'($urandom()));
                endcase
            end
            made += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int r;
        int nbits;
        int hdim;
        int rowb;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: one bank, unit head dimension. Cold miss, repeat
        // hit, neighbor in the same row, field extremes, alternating bits.
        queue_access('0, '0);
        queue_access('0, '0);
        queue_access('0, HEAD_W'(1));
        queue_access('1, '1);
        queue_access('1, '1);
        queue_access(TOKEN_W'(20'hAAAAA), HEAD_W'(10'h155));
        queue_access(TOKEN_W'(20'h55555), HEAD_W'(10'h2AA));
        wait_drained();

        // Widest multiplier with divisor 1: the row overflows 40 bits and is
        // truncated. All costs at their maximum.
        set_config(0, 2047, 3, 255, 255, 255);
        queue_access('1, '1);
        queue_access('1, '1);
        queue_access('0, '0);
        queue_access('0, '0);
        queue_access(TOKEN_W'(1), '0);
        wait_drained();

        // Zero head dimension (every row is 0), bank count above the limit,
        // largest row size, zero costs. Writes past the register file must
        // leave all of this untouched.
        set_config(7, 0, 131071, 0, 0, 0);
        write_reg(REG_SPARE, $urandom());
        write_reg(REG_SPARE + 1, $urandom());
        queue_access('0, '0);
        queue_access(TOKEN_W'(1), '0);
        queue_access('0, HEAD_W'(1));
        queue_access(TOKEN_W'(15), '0);
        queue_access('1, '1);
        queue_access(TOKEN_W'(20'hAAAAA), HEAD_W'(10'h155));
        wait_drained();

        // Random phases, each with fresh settings for every register
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            nbits = $urandom_range(0, 7);
            r = $urandom_range(0, 7);
            if (r == 0)
                hdim = 0;
            else if (r == 1)
                hdim = 2047;
            else if (r < 4)
                hdim = $urandom_range(1, 1024);
            else
                hdim = $urandom_range(1, 16);
            r = $urandom_range(0, 7);
            if (r == 0)
                rowb = $urandom_range(0, 7);
            else if (r == 1)
                rowb = 131071;
            else
                rowb = $urandom_range(0, 131071);
            set_config(nbits, hdim, rowb, pick_cost(), pick_cost(), pick_cost());
            fill_random(PHASE_ITEMS);
            wait_drained();
        end

        // Drain margin: block latency plus slack for a stray late beat
        repeat (100) @(posedge i_clk);
        if (outcome_queue.size() != 0)
            $display("%0t: %0d expected results never arrived",
                     $time, outcome_queue.size());
        if (errors == 0 && outcome_queue.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
